// ===== rtl/scope_record_averager_min_max_defines.svh =====
// Assertion macros for the checker file of the scope record averager.
`ifndef SCOPE_RECORD_AVERAGER_MIN_MAX_DEFINES_SVH
`define SCOPE_RECORD_AVERAGER_MIN_MAX_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset as the disable condition.
`define SRAMM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a property that must hold on the cycle after its antecedent.
`define SRAMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sramm_pkg.sv =====
// Package with types and constants of the scope record averager.
`timescale 1ns / 1ps
`default_nettype none

package sramm_pkg;

  // Default configuration of the record geometry.
  localparam int unsigned PointsDefault     = 158;
  localparam int unsigned MaxAverageDefault = 10;

  // Field widths.
  localparam int unsigned SampleW   = 12;
  localparam int unsigned SumW      = 16;
  localparam int unsigned FactorW   = 4;
  localparam int unsigned GainW     = 3;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned ValueW    = 15;
  localparam int unsigned RowW      = 11;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 4;

  // Screen mapping and scaling constants.
  localparam int unsigned ScreenMid      = 60;
  localparam int unsigned ScreenSpan     = 120;
  localparam int unsigned FullScaleShift = 12;
  localparam int unsigned MaxGainShift   = 4;
  localparam int unsigned ValueSat       = 32767;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegAvgFactor = 1'b0;
  localparam logic [CfgIndexW-1:0] RegGainShift = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_EMIT
  } sramm_state_e;

endpackage

`default_nettype wire

// ===== rtl/scope_record_averager_min_max.sv =====
// Top level of the scope record averager: boxcar decimation, gain, row map, peak tracking.
`timescale 1ns / 1ps
`default_nettype none

// A sample that completes a group gives its point after the shared restoring divider, one scale
// step and the load into the output register. Samples that do not complete a group are taken one
// per cycle while no point is in work; a point-completing sample holds in_stall_o high until its
// point is in the output register, longer if that register is still held by a stall.
// Reset clears the configuration to avg_factor 1 and gain_shift 1 and empties all accumulators.
module scope_record_averager_min_max #(
  parameter int unsigned POINTS      = sramm_pkg::PointsDefault,
  parameter int unsigned MAX_AVERAGE = sramm_pkg::MaxAverageDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration write port.
  input  wire                                  cfg_we_i,
  input  wire  [sramm_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  wire  [sramm_pkg::CfgDataW-1:0]       cfg_data_i,
  // Sample channel.
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [sramm_pkg::SampleW-1:0]        adc_sample_i,
  // Point channel.
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [sramm_pkg::IndexW-1:0]         point_index_o,
  output logic [sramm_pkg::ValueW-1:0]         point_value_o,
  output logic signed [sramm_pkg::RowW-1:0]    screen_row_o,
  output logic                                 record_last_o,
  output logic [sramm_pkg::SampleW-1:0]        record_max_o,
  output logic [sramm_pkg::SampleW-1:0]        record_min_o
);
  import sramm_pkg::*;

  // Derived constants. The point counter is a fixed 8 bits, so the last index is cast down.
  localparam logic [IndexW-1:0]  LastIdx   = IndexW'(POINTS - 1);
  localparam logic [FactorW-1:0] MaxFactor = FactorW'(MAX_AVERAGE);
  localparam logic [GainW-1:0]   MaxShift  = GainW'(MaxGainShift);
  localparam int unsigned        ProdW     = ValueW + 7;

  // Configuration registers.
  logic [FactorW-1:0] avg_factor_q;
  logic [GainW-1:0]   gain_shift_q;

  // Sequencer and accumulation state.
  sramm_state_e       state_q, state_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [FactorW-1:0] group_q, group_d;
  logic [IndexW-1:0]  point_q, point_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SampleW-1:0] min_q, min_d;

  // Shared divider: the dividend register shifts left and collects quotient bits.
  logic [FactorW-1:0] divisor_q, divisor_d;
  logic [SumW-1:0]    quot_q, quot_d;
  logic [FactorW-1:0] rem_q, rem_d;
  logic [3:0]         step_q, step_d;

  // Per-point values held between the scale and emit steps.
  logic [IndexW-1:0]  idx_q, idx_d;
  logic               last_q, last_d;
  logic [ValueW-1:0]  scaled_q, scaled_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [IndexW-1:0]        point_index_q;
  logic [ValueW-1:0]        point_value_q;
  logic signed [RowW-1:0]   screen_row_q;
  logic                     record_last_q;
  logic [SampleW-1:0]       record_max_q;
  logic [SampleW-1:0]       record_min_q;

  // Combinational helpers.
  logic               in_beat;
  logic               out_beat;
  logic               out_free;
  logic               load_out;
  logic [FactorW-1:0] factor;
  logic [GainW-1:0]   shift;
  logic [SumW-1:0]    sum_new;
  logic [FactorW-1:0] group_new;
  logic               group_done;
  logic [FactorW:0]   rem_sh;
  logic               rem_ge;
  logic [FactorW:0]   rem_diff;
  logic [SampleW-1:0] avg;
  logic [SumW-1:0]    shifted;
  logic [ProdW-1:0]   prod;
  logic signed [RowW-1:0] row;

  // Effective factor and gain: zero factor acts as one, large values are clamped.
  always_comb begin
    if (avg_factor_q == '0) begin
      factor = FactorW'(1);
    end else if (avg_factor_q > MaxFactor) begin
      factor = MaxFactor;
    end else begin
      factor = avg_factor_q;
    end
    shift = (gain_shift_q > MaxShift) ? MaxShift : gain_shift_q;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sum_new    = sum_q + SumW'(adc_sample_i);
  assign group_new  = group_q + FactorW'(1);
  assign group_done = (group_new >= factor);

  // One restoring step of the divider: shift in the next dividend bit and try a subtract.
  assign rem_sh   = {rem_q, quot_q[SumW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor_q});
  assign rem_diff = rem_sh - {1'b0, divisor_q};

  // The average keeps only its low 12 bits, as a lowered factor can leave a larger quotient.
  // It is widened to the full 16 bits before the shift so that no gain bit is lost.
  assign avg     = quot_q[SampleW-1:0];
  assign shifted = {{(SumW-SampleW){1'b0}}, avg} << shift;

  // Row mapping: 60 minus the scaled value times 120 over full scale.
  assign prod = ProdW'(scaled_q) * ProdW'(ScreenSpan);
  assign row  = RowW'(ScreenMid) - RowW'(prod[ProdW-1:FullScaleShift]);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat && group_done) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step_q == 4'hF) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath controls and register updates per state.
  always_comb begin
    sum_d     = sum_q;
    group_d   = group_q;
    point_d   = point_q;
    max_d     = max_q;
    min_d     = min_q;
    divisor_d = divisor_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    step_d    = step_q;
    idx_d     = idx_q;
    last_d    = last_q;
    scaled_d  = scaled_q;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (group_done) begin
            // The group is complete: hand the sum to the divider and start a new group.
            sum_d     = '0;
            group_d   = '0;
            divisor_d = factor;
            quot_d    = sum_new;
            rem_d     = '0;
            step_d    = '0;
          end else begin
            sum_d   = sum_new;
            group_d = group_new;
          end
        end
      end
      ST_DIVIDE: begin
        rem_d  = rem_ge ? rem_diff[FactorW-1:0] : rem_sh[FactorW-1:0];
        quot_d = {quot_q[SumW-2:0], rem_ge};
        step_d = step_q + 4'd1;
      end
      ST_SCALE: begin
        idx_d = point_q;
        if (point_q == '0) begin
          max_d = avg;
          min_d = avg;
        end else begin
          if (avg > max_q) begin
            max_d = avg;
          end
          if (avg < min_q) begin
            min_d = avg;
          end
        end
        scaled_d = (shifted > SumW'(ValueSat)) ? ValueW'(ValueSat) : shifted[ValueW-1:0];
        last_d   = (point_q >= LastIdx);
        point_d  = (point_q >= LastIdx) ? '0 : point_q + IndexW'(1);
      end
      ST_EMIT: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_beat) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_factor_q <= FactorW'(1);
      gain_shift_q <= GainW'(1);
      state_q      <= ST_IDLE;
      sum_q        <= '0;
      group_q      <= '0;
      point_q      <= '0;
      max_q        <= '0;
      min_q        <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == RegAvgFactor)) begin
        avg_factor_q <= cfg_data_i[FactorW-1:0];
      end
      if (cfg_we_i && (cfg_index_i == RegGainShift)) begin
        gain_shift_q <= cfg_data_i[GainW-1:0];
      end
      state_q     <= state_d;
      sum_q       <= sum_d;
      group_q     <= group_d;
      point_q     <= point_d;
      max_q       <= max_d;
      min_q       <= min_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    last_q    <= last_d;
    scaled_q  <= scaled_d;
    if (load_out) begin
      point_index_q <= idx_q;
      point_value_q <= scaled_q;
      screen_row_q  <= row;
      record_last_q <= last_q;
      record_max_q  <= last_q ? max_q : '0;
      record_min_q  <= last_q ? min_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_index_o = point_index_q;
  assign point_value_o = point_value_q;
  assign screen_row_o  = screen_row_q;
  assign record_last_o = record_last_q;
  assign record_max_o  = record_max_q;
  assign record_min_o  = record_min_q;

endmodule

`default_nettype wire

// ===== rtl/sramm_checker.sv =====
// Port-level checker for the scope record averager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "scope_record_averager_min_max_defines.svh"

module sramm_checker #(
  parameter int unsigned POINTS = sramm_pkg::PointsDefault
) (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  out_valid_o,
  input wire                                  out_stall_i,
  input wire [sramm_pkg::IndexW-1:0]          point_index_o,
  input wire                                  record_last_o,
  input wire [sramm_pkg::SampleW-1:0]         record_max_o,
  input wire [sramm_pkg::SampleW-1:0]         record_min_o
);
  import sramm_pkg::*;

  localparam logic [IndexW-1:0] LastIdx = IndexW'(POINTS - 1);

  // A stalled point beat stays offered.
  `SRAMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "point beat dropped while stalled")

  // The last flag marks exactly the final index of a record.
  `SRAMM_ASSERT(a_last_index, clk_i, rst_ni, out_valid_o |-> (record_last_o == (point_index_o == LastIdx)), "record_last does not match point index")

  // Peaks are reported only with the last point.
  `SRAMM_ASSERT(a_peak_zero, clk_i, rst_ni, (out_valid_o && !record_last_o) |-> ((record_max_o == '0) && (record_min_o == '0)), "peak fields nonzero before record end")

  // The tracked minimum never exceeds the tracked maximum.
  `SRAMM_ASSERT(a_peak_order, clk_i, rst_ni, (out_valid_o && record_last_o) |-> (record_min_o <= record_max_o), "record_min above record_max")

endmodule

bind scope_record_averager_min_max sramm_checker #(.POINTS(POINTS)) u_sramm_checker (.*);

`default_nettype wire

// ===== test/scope_record_averager_min_max_tb.sv =====
// Self-checking testbench for the scope record averager with min/max tracking.
`timescale 1ns / 1ps

module scope_record_averager_min_max_tb;
  import sramm_pkg::*;

  // The watchdog fires after this many cycles in which no beat moves on either channel.
  localparam int unsigned QuietLimit   = 4000;
  // After the last expected point has been seen, this many cycles pass before the
  // configuration is touched again.
  localparam int unsigned DrainCycles  = 24;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseSamples = 118;

  // One record point, as it leaves the block.
  typedef struct {
    logic [IndexW-1:0]         index;
    logic [ValueW-1:0]         value;
    logic signed [RowW-1:0]    row;
    logic                      last;
    logic [SampleW-1:0]        max;
    logic [SampleW-1:0]        min;
  } point_t;

  // Mirrors the averager state and holds the points that are still due, oldest first.
  class point_scoreboard;
    logic [FactorW-1:0] avg_factor;
    logic [GainW-1:0]   gain_shift;
    logic [SumW-1:0]    sample_sum;
    logic [FactorW-1:0] group_count;
    logic [IndexW-1:0]  point_count;
    logic [SampleW-1:0] peak_max;
    logic [SampleW-1:0] peak_min;
    point_t             pending[$];
    int unsigned        mismatches;
    int unsigned        points_seen;
    int unsigned        records_seen;

    function new();
      avg_factor   = 1;
      gain_shift   = 1;
      sample_sum   = '0;
      group_count  = '0;
      point_count  = '0;
      peak_max     = '0;
      peak_min     = '0;
      mismatches   = 0;
      points_seen  = 0;
      records_seen = 0;
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
      case (index)
        RegAvgFactor: avg_factor = data[FactorW-1:0];
        RegGainShift: gain_shift = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    // Adds one accepted sample to the running group. When the group is full,
    // the point that the block has to produce is queued.
    function void note_sample(logic [SampleW-1:0] sample);
      int unsigned factor;
      int unsigned shift;
      int unsigned avg;
      int unsigned scaled;
      int          row_full;
      logic        last;
      point_t      p;
      sample_sum  = sample_sum + {{(SumW-SampleW){1'b0}}, sample};
      group_count = group_count + 1'b1;
      factor = (avg_factor == 0) ? 1 : avg_factor;
      if (factor > MaxAverageDefault) factor = MaxAverageDefault;
      if (group_count < factor) return;

      // A lowered factor can leave more samples in the sum than it divides by;
      // the average then wraps to 12 bits.
      avg = (32'(sample_sum) / factor) & 32'hFFF;
      sample_sum  = '0;
      group_count = '0;

      if (point_count == 0) begin
        peak_max = avg[SampleW-1:0];
        peak_min = avg[SampleW-1:0];
      end else begin
        if (avg > peak_max) peak_max = avg[SampleW-1:0];
        if (avg < peak_min) peak_min = avg[SampleW-1:0];
      end

      shift  = (gain_shift > MaxGainShift) ? MaxGainShift : gain_shift;
      scaled = avg << shift;
      if (scaled > ValueSat) scaled = ValueSat;
      row_full = int'(ScreenMid) - int'((scaled * ScreenSpan) >> FullScaleShift);
      last     = (point_count >= PointsDefault - 1);

      p.index = point_count;
      p.value = scaled[ValueW-1:0];
      p.row   = row_full[RowW-1:0];
      p.last  = last;
      p.max   = last ? peak_max : '0;
      p.min   = last ? peak_min : '0;
      pending.push_back(p);

      point_count = last ? '0 : point_count + 1'b1;
    endfunction

    function void check_point(point_t got);
      point_t want;
      points_seen++;
      if (got.last === 1'b1) records_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: point index %0d value %0d arrived with none expected",
                   $time, got.index, got.value);
        return;
      end
      want = pending.pop_front();
      if (got.index !== want.index || got.value !== want.value || got.row !== want.row ||
          got.last !== want.last || got.max !== want.max || got.min !== want.min) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: point mismatch, expected idx %0d val %0d row %0d last %0b max %0d min %0d",
                   $time, want.index, want.value, want.row, want.last, want.max, want.min);
          $display("%0t:                 got      idx %0d val %0d row %0d last %0b max %0d min %0d",
                   $time, got.index, got.value, got.row, got.last, got.max, got.min);
        end
      end
    endfunction

    // Points still owed count as failures too.
    function int unsigned errors();
      return mismatches + pending.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIndexW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [SampleW-1:0]       adc_sample_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [IndexW-1:0]        point_index_o;
  logic [ValueW-1:0]        point_value_o;
  logic signed [RowW-1:0]   screen_row_o;
  logic                     record_last_o;
  logic [SampleW-1:0]       record_max_o;
  logic [SampleW-1:0]       record_min_o;

  point_scoreboard sb = new();

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  // Centre of the slowly varying signal that part of the random samples follow.
  int unsigned signal_level;
  int unsigned samples_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  // Factor and gain per random phase. The list holds the extremes, the zero factor,
  // factors and gains above their limits, and several drops of the factor, so that
  // a partly filled group meets a smaller factor.
  logic [CfgDataW-1:0] phase_avg  [NumPhases] = '{1, 10, 0, 3, 15, 1, 2, 7, 1, 12, 4, 1};
  logic [CfgDataW-1:0] phase_gain [NumPhases] = '{0, 4, 7, 2, 1, 3, 5, 6, 1, 0, 4, 2};

  scope_record_averager_min_max u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .adc_sample_i  (adc_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_index_o (point_index_o),
    .point_value_o (point_value_o),
    .screen_row_o  (screen_row_o),
    .record_last_o (record_last_o),
    .record_max_o  (record_max_o),
    .record_min_o  (record_min_o)
  );

  always #5 clk_i = ~clk_i;

  // The receiver: checks every point beat against the oldest expected point, then
  // decides whether to stall the next cycle. The values seen at the edge are the
  // ones from before it, so a beat is exactly valid high with stall low here.
  always @(posedge clk_i) begin : receive_points
    point_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.index = point_index_o;
      got.value = point_value_o;
      got.row   = screen_row_o;
      got.last  = record_last_o;
      got.max   = record_max_o;
      got.min   = record_min_o;
      sb.check_point(got);
    end
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // The watchdog ends a run that has hung: no beat on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no beat for %0d cycles, %0d points still due",
               $time, QuietLimit, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mode 0: the sender idles now and then and the receiver often stalls.
  // Mode 1 swaps the two. Mode 2 runs both sides flat out.
  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin
        in_idle_pct  = 15;
        out_idle_pct = 62;
      end
      1: begin
        in_idle_pct  = 62;
        out_idle_pct = 15;
      end
      default: begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
    endcase
  endtask

  // Sends one sample beat, with random gaps ahead of it. The task returns at the
  // edge that accepted the beat, so the next call can keep valid high.
  task automatic send_sample(input logic [SampleW-1:0] sample);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(sample);
    samples_sent++;
  endtask

  // Brings the block to rest: all expected points out, then time for any divide
  // still running on a group that the testbench has not yet counted.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes both registers, the factor first and then the gain, on consecutive edges. The model is updated at the
  // edge that performs each write.
  task automatic write_settings(input logic [CfgDataW-1:0] avg,
                                input logic [CfgDataW-1:0] gain);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegAvgFactor;
    cfg_data_i  <= avg;
    @(posedge clk_i);
    sb.write_reg(RegAvgFactor, avg);
    cfg_index_i <= RegGainShift;
    cfg_data_i  <= gain;
    @(posedge clk_i);
    sb.write_reg(RegGainShift, gain);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random samples of several kinds: full range in four draws out of ten, then rail
  // values, a noisy level like a real trace, single set bits, and values close
  // to either end of the converter range.
  function automatic logic [SampleW-1:0] next_sample();
    int unsigned kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: return SampleW'($urandom);
      4:          return $urandom_range(1) ? '1 : '0;
      5, 6:       return SampleW'(signal_level + $urandom_range(40) - 20);
      7:          return SampleW'(1 << $urandom_range(SampleW - 1));
      8:          return SampleW'($urandom_range(15));
      default:    return SampleW'(4095 - $urandom_range(15));
    endcase
  endfunction

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = RegAvgFactor;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    adc_sample_i = '0;
    out_stall_i  = 1'b0;
    quiet_cycles = 0;
    samples_sent = 0;
    settings_used = 0;
    signal_level = 2048;
    set_idle_mode(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The reset settings (factor 1, gain x2) come first: both rails,
    // mid scale, and the two alternating bit patterns. Point zero of the first
    // record loads the min and max trackers.
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'hAAA);
    send_sample(12'h555);

    // A zero factor acts as one; a gain exponent of seven acts as four. Full scale
    // then saturates and lands on the lowest screen row.
    settle();
    write_settings(4'd0, 4'd7);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd136);

    // A factor of fifteen acts as ten: ten full-scale samples give one point. Three
    // more are left in the group for the next step.
    settle();
    write_settings(4'd15, 4'd0);
    repeat (10) send_sample(12'd4095);
    repeat (3) send_sample(12'd4095);

    // The factor drops to two with three samples already gathered, so the next sample
    // closes the group. Four full-scale samples over two wrap to 4094 in 12 bits.
    settle();
    write_settings(4'd2, 4'd4);
    send_sample(12'd4095);

    // Random part: twelve phases with their own settings. The group and the record
    // carry over from phase to phase, so records span several settings.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      settle();
      set_idle_mode(ph / 4);
      signal_level = $urandom_range(100, 3995);
      write_settings(phase_avg[ph], phase_gain[ph]);
      repeat (PhaseSamples) send_sample(next_sample());
    end
    settle();

    $display("Sent %0d samples over %0d register settings; checked %0d points, %0d full records.",
             samples_sent, settings_used, sb.points_seen, sb.records_seen);
    $display("Idle mix: slow sender and slow receiver in turn, then both sides at full rate.");
    if (sb.errors() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d points never arrived", sb.mismatches, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
